// ----- hdl/sensor_frame_deframer_unit_assert.svh -----
// Assertion helpers for the deframer top-level RTL.
`ifndef SENSOR_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define SENSOR_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/sfd_pkg.sv -----
package sfd_pkg;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 32;
  localparam int HEAD_W  = 16;
  localparam int DEG_W   = 38;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (2 * DEG_W + HEAD_W + BYTE_W + 1);

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;

  // Frame byte positions after the sync pair
  localparam logic [3:0] HEAD_LO_POS = 4'd8;
  localparam logic [3:0] CHECK_POS   = 4'd10;

  // count / 2048 * 360 * 256 reduces exactly to count * 45
  localparam logic signed [DEG_W-1:0] DEG_Q8_PER_COUNT = 38'sd45;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'b001,
    PH_ARMED  = 3'b010,
    PH_GATHER = 3'b100
  } phase_t;

  typedef struct packed {
    logic [COUNT_W-1:0] left_count;
    logic [COUNT_W-1:0] right_count;
    logic [HEAD_W-1:0]  heading;
    logic [BYTE_W-1:0]  check_byte;
    logic               check_ok;
  } frame_t;

endpackage

// ----- hdl/sfd_parser.sv -----
module sfd_parser import sfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              in_take,
  output logic              res_valid,
  input  logic              res_ready,
  output frame_t            res
);

  phase_t             phase;
  logic [3:0]         pos;
  logic [COUNT_W-1:0] left_count;
  logic [COUNT_W-1:0] right_count;
  logic [HEAD_W-1:0]  heading_word;
  logic [BYTE_W-1:0]  running_xor;
  logic               is_check;
  logic               slot_free;

  // Only the check byte needs room in the result register
  assign is_check  = (phase == PH_GATHER) && (pos >= CHECK_POS);
  assign slot_free = !res_valid || res_ready;
  assign in_take   = in_valid && (!is_check || slot_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      pos          <= '0;
      left_count   <= '0;
      right_count  <= '0;
      heading_word <= '0;
      running_xor  <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (in_take) begin
        case (phase)
          PH_GATHER: begin
            if (is_check) begin
              res.left_count  <= left_count;
              res.right_count <= right_count;
              res.heading     <= heading_word;
              res.check_byte  <= in_byte;
              res.check_ok    <= (in_byte == running_xor);
              res_valid       <= 1'b1;
              phase           <= PH_HUNT;
              pos             <= '0;
            end else begin
              case (pos) inside
                [4'd0:4'd3]: begin
                  left_count[{pos[1:0], 3'b000} +: BYTE_W] <= in_byte;
                end
                [4'd4:4'd7]: begin
                  right_count[{pos[1:0], 3'b000} +: BYTE_W] <= in_byte;
                end
                HEAD_LO_POS: begin
                  heading_word[BYTE_W-1:0] <= in_byte;
                end
                default: begin
                  heading_word[HEAD_W-1:BYTE_W] <= in_byte;
                end
              endcase
              running_xor <= running_xor ^ in_byte;
              pos         <= pos + 4'd1;
            end
          end
          PH_ARMED: begin
            if (in_byte == SYNC_SECOND) begin
              phase       <= PH_GATHER;
              pos         <= '0;
              running_xor <= '0;
            end else if (in_byte != SYNC_FIRST) begin
              phase <= PH_HUNT;
            end
          end
          default: begin
            phase <= (in_byte == SYNC_FIRST) ? PH_ARMED : PH_HUNT;
          end
        endcase
      end
    end
  end

endmodule

// ----- hdl/sfd_scale.sv -----
module sfd_scale import sfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  output logic                   res_ready,
  input  frame_t                 res,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic signed [DEG_W-1:0] left_ext;
  logic signed [DEG_W-1:0] right_ext;
  logic signed [DEG_W-1:0] left_deg;
  logic signed [DEG_W-1:0] right_deg;

  // Sign-extend to the result width first so the product wraps at 38 bits
  assign left_ext  = {{(DEG_W-COUNT_W){res.left_count[COUNT_W-1]}}, res.left_count};
  assign right_ext = {{(DEG_W-COUNT_W){res.right_count[COUNT_W-1]}}, res.right_count};
  assign left_deg  = left_ext * DEG_Q8_PER_COUNT;
  assign right_deg = right_ext * DEG_Q8_PER_COUNT;

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, res.check_ok, res.check_byte, res.heading,
                  right_deg, left_deg};
    end
  end

endmodule

// ----- hdl/sensor_frame_deframer_unit.sv -----
// Sync-word frame parser for a serial sensor byte stream.
//
// Slave channel (s_*): one received byte per transfer. Master channel (m_*):
// one transfer per completed frame carrying both encoder angles (count * 45,
// degrees in Q8), the raw heading in tenths, the received check byte and a
// flag telling whether it matches the XOR of the ten payload bytes.
//
// A frame is 0xAA 0x55 followed by eleven bytes; a repeated 0xAA keeps the
// hunt armed, any other byte drops back to hunting. Inside a frame every
// byte is data. A bad check byte still produces a result with check_ok low.
//
// Throughput: one byte per cycle while no check byte is held. Path: a
// result goes from the check byte in the input register to the parser
// result register, then via the scaling multiply into the output register.
// Stall: bytes that end no frame keep flowing while a result waits on
// m_tready; only a check byte is held in the input register until the
// result register has room, which then drops s_tready.
// Reset: synchronous, active high; clears the hunt state and all valids.
`include "sensor_frame_deframer_unit_assert.svh"

module sensor_frame_deframer_unit import sfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [BYTE_W-1:0]      s_tdata,  // [7:0] data_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [37:0] left_deg_q8, [75:38] right_deg_q8, [91:76] heading_tenths,
  // [99:92] check_byte, [100] check_ok, [103:101] zero
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_take;
  logic              p_valid;
  logic              p_ready;
  frame_t            p_res;

  // Input register: refill whenever the held byte moves on or none is held
  assign s_tready = !in_valid || in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // Hunt for sync, gather fields, latch the raw frame
  sfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .in_take   (in_take),
    .res_valid (p_valid),
    .res_ready (p_ready),
    .res       (p_res)
  );

  // Scale counts to degrees and drive the output register
  sfd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .res_valid (p_valid),
    .res_ready (p_ready),
    .res       (p_res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // A stalled slave side always means a byte is held
  `SFD_ASSERT_NOW(a_stall_holds_byte, !s_tready, in_valid, "s_tready low with empty input register")
  // A frame handed to the scaler shows up on the master side next cycle
  `SFD_ASSERT_NEXT(a_frame_to_output, p_valid && p_ready, m_tvalid, "frame lost on way to output")
  // Heading passes through the scaler unchanged
  `SFD_ASSERT_NEXT(a_heading_kept, p_valid && p_ready, m_tdata[91:76] == $past(p_res.heading), "heading corrupted in scaler")

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import sfd_pkg::*;

  localparam logic signed [DEG_W-1:0] ANGLE_Q8_PER_COUNT = 38'sd45;
  localparam int RANDOM_BYTES = 900;
  localparam int MAX_SHOWN    = 10;

  typedef struct {
    logic [BYTE_W-1:0] value;
    bit                drain_first;  // wait for every pending frame result first
  } stream_byte_t;

  typedef struct packed {
    logic signed [DEG_W-1:0] left_deg;
    logic signed [DEG_W-1:0] right_deg;
    logic [HEAD_W-1:0]       heading;
    logic [BYTE_W-1:0]       chk;
    logic                    chk_ok;
  } angle_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [BYTE_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  sensor_frame_deframer_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  stream_byte_t  byte_q[$];
  angle_report_t frames_due[$];

  int bytes_sent = 0;
  int total_bytes = 0;
  int frames_checked = 0;
  int bad_checks_seen = 0;
  int err_cnt = 0;
  int hold_left = 0;
  int holds_done = 0;

  // Shadow parser state
  phase_t            parse_phase = PH_HUNT;
  logic [3:0]        frame_pos = '0;
  logic [COUNT_W-1:0] left_cnt = '0;
  logic [COUNT_W-1:0] right_cnt = '0;
  logic [HEAD_W-1:0] head_word = '0;
  logic [BYTE_W-1:0] xor_acc = '0;

  function automatic logic signed [DEG_W-1:0] count_to_deg_q8(input logic [COUNT_W-1:0] c);
    logic signed [DEG_W-1:0] wide;
    wide = {{(DEG_W-COUNT_W){c[COUNT_W-1]}}, c};
    return wide * ANGLE_Q8_PER_COUNT;
  endfunction

  // Advance the shadow parser by one byte; queue a report when a frame closes.
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    angle_report_t rep;
    case (parse_phase)
      PH_GATHER: begin
        if (frame_pos >= CHECK_POS) begin
          rep.left_deg  = count_to_deg_q8(left_cnt);
          rep.right_deg = count_to_deg_q8(right_cnt);
          rep.heading   = head_word;
          rep.chk       = b;
          rep.chk_ok    = (b == xor_acc);
          frames_due.push_back(rep);
          parse_phase = PH_HUNT;
          frame_pos   = '0;
        end else begin
          if (frame_pos < 4) left_cnt[frame_pos[1:0]*8 +: 8] = b;
          else if (frame_pos < 8) right_cnt[frame_pos[1:0]*8 +: 8] = b;
          else if (frame_pos == HEAD_LO_POS) head_word[7:0] = b;
          else head_word[15:8] = b;
          xor_acc   = xor_acc ^ b;
          frame_pos = frame_pos + 4'd1;
        end
      end
      PH_ARMED: begin
        if (b == SYNC_SECOND) begin
          parse_phase = PH_GATHER;
          frame_pos   = '0;
          xor_acc     = '0;
        end else if (b != SYNC_FIRST) begin
          parse_phase = PH_HUNT;
        end
      end
      default: parse_phase = (b == SYNC_FIRST) ? PH_ARMED : PH_HUNT;
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    err_cnt++;
    if (err_cnt <= MAX_SHOWN)
      $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] b, input bit drain);
    stream_byte_t item;
    item.value = b;
    item.drain_first = drain;
    byte_q.push_back(item);
  endtask

  // Queue sync pair, payload and check byte; corrupt the check when asked.
  task automatic queue_frame(input logic [COUNT_W-1:0] l, input logic [COUNT_W-1:0] r,
                             input logic [HEAD_W-1:0] h, input bit good_chk,
                             input bit drain);
    logic [79:0] payload;
    logic [BYTE_W-1:0] chk;
    payload = {h, r, l};
    chk = '0;
    queue_byte(SYNC_FIRST, drain);
    queue_byte(SYNC_SECOND, 1'b0);
    for (int i = 0; i < 10; i++) begin
      queue_byte(payload[i*8 +: 8], 1'b0);
      chk = chk ^ payload[i*8 +: 8];
    end
    if (!good_chk) chk = chk ^ (8'h1 << $urandom_range(0, 7));
    queue_byte(chk, 1'b0);
  endtask

  // Driver: predict on each transfer, then present the next byte after its gap.
  int tx_gap = 0;
  bit tx_burst = 1'b0;
  stream_byte_t tx_item;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      tx_gap = 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        deframe_byte(s_tdata);
        bytes_sent <= bytes_sent + 1;
      end
      if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (byte_q.size() != 0 &&
                   !(byte_q[0].drain_first && frames_due.size() != 0)) begin
        tx_item = byte_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= tx_item.value;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off: twice, drop ready while hold_left counts down so the input backs up.
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && bytes_sent >= 150) ||
                 (holds_done == 1 && bytes_sent >= 600)) begin
      hold_left  <= 400;
      holds_done <= holds_done + 1;
    end
  end

  // Monitor: check each result transfer against the oldest prediction.
  int rx_wait = 0;
  bit rx_burst = 1'b0;
  angle_report_t want_rep;
  angle_report_t got_rep;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_rep.left_deg  = m_tdata[37:0];
        got_rep.right_deg = m_tdata[75:38];
        got_rep.heading   = m_tdata[91:76];
        got_rep.chk       = m_tdata[99:92];
        got_rep.chk_ok    = m_tdata[100];
        frames_checked++;
        if (!got_rep.chk_ok) bad_checks_seen++;
        if (frames_due.size() == 0) begin
          note_mismatch("unexpected result, left_deg_q8", '0, 64'(got_rep.left_deg));
        end else begin
          want_rep = frames_due.pop_front();
          if (got_rep.left_deg !== want_rep.left_deg)
            note_mismatch("left_deg_q8", 64'(want_rep.left_deg), 64'(got_rep.left_deg));
          if (got_rep.right_deg !== want_rep.right_deg)
            note_mismatch("right_deg_q8", 64'(want_rep.right_deg), 64'(got_rep.right_deg));
          if (got_rep.heading !== want_rep.heading)
            note_mismatch("heading_tenths", 64'(want_rep.heading), 64'(got_rep.heading));
          if (got_rep.chk !== want_rep.chk)
            note_mismatch("check_byte", 64'(want_rep.chk), 64'(got_rep.chk));
          if (got_rep.chk_ok !== want_rep.chk_ok)
            note_mismatch("check_ok", 64'(want_rep.chk_ok), 64'(got_rep.chk_ok));
        end
        if (m_tdata[103:101] !== 3'b000)
          note_mismatch("tdata padding", '0, 64'(m_tdata[103:101]));
        rx_wait = rx_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      m_tready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int kind;
    int n;
    bit drain;
    bit first_frame;
    logic [COUNT_W-1:0] l;
    logic [COUNT_W-1:0] r;
    logic [HEAD_W-1:0] h;
    logic [BYTE_W-1:0] b;

    // Broken sync, then a repeated sync byte ahead of a frame with extreme fields
    queue_byte(SYNC_FIRST, 1'b0);
    queue_byte(8'h12, 1'b0);
    queue_byte(SYNC_FIRST, 1'b0);
    queue_frame(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, 1'b0);
    // Sync bytes inside the payload, bad check
    queue_frame(32'h55AA_55AA, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0);

    first_frame = 1'b1;
    while (byte_q.size() < RANDOM_BYTES + 28) begin
      kind  = $urandom_range(0, 9);
      drain = first_frame || ($urandom_range(0, 11) == 0);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        queue_byte(BYTE_W'($urandom_range(0, 255)), drain);
        drain = 1'b0;
      end
      if (kind == 0) begin
        // Broken sync: the second byte is anything but the second sync byte
        do b = BYTE_W'($urandom_range(0, 255)); while (b == SYNC_SECOND);
        queue_byte(SYNC_FIRST, drain);
        queue_byte(b, 1'b0);
      end else if (kind == 1) begin
        n = $urandom_range(4, 12);
        for (int i = 0; i < n; i++) begin
          queue_byte(BYTE_W'($urandom_range(0, 255)), drain);
          drain = 1'b0;
        end
      end else begin
        l = $urandom();
        r = $urandom();
        h = HEAD_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 7) == 0) l = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if ($urandom_range(0, 7) == 0) r = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        if ($urandom_range(0, 3) == 0) begin
          queue_byte(SYNC_FIRST, drain);
          drain = 1'b0;
        end
        queue_frame(l, r, h, $urandom_range(0, 3) != 0, drain);
        first_frame = 1'b0;
      end
    end
    total_bytes = byte_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (bytes_sent != total_bytes) @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    for (int i = 0; i < frames_due.size(); i++)
      note_mismatch("missing result, left_deg_q8", 64'(frames_due[i].left_deg), '0);

    $display("Streamed %0d bytes, checked %0d decoded frames (%0d with a failed check byte).",
             bytes_sent, frames_checked, bad_checks_seen);
    $display("Receiver hold-offs: %0d, mismatches: %0d.", holds_done, err_cnt);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run timed out with %0d of %0d bytes sent.", bytes_sent, total_bytes);
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/sfd_pkg.sv
hdl/sfd_parser.sv
hdl/sfd_scale.sv
hdl/sensor_frame_deframer_unit.sv
sim/testbench.sv
